@@ rtl/lnp_pkg.sv @@
// Shared types, codes and constants of the line-number program interpreter.
package lnp_pkg;

  localparam int unsigned OPCODE_TABLE_DEPTH_DEF = 256;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [1:0] OPN_BYTE  = 2'd0;
  localparam logic [1:0] OPN_LOAD  = 2'd1;
  localparam logic [1:0] OPN_BEGIN = 2'd2;
  localparam logic [1:0] OPN_NONE  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_MIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_SPAN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SPECIAL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_STMT  = 3'd4;

  localparam logic [7:0] DEF_MIN_LEN       = 8'd1;
  localparam logic [7:0] DEF_LINE_MIN      = 8'hfb;
  localparam logic [7:0] DEF_LINE_SPAN     = 8'd14;
  localparam logic [7:0] DEF_FIRST_SPECIAL = 8'd13;
  localparam logic       DEF_STMT          = 1'b1;

  localparam logic [7:0] OP_EXTENDED       = 8'd0;
  localparam logic [7:0] OP_COPY           = 8'd1;
  localparam logic [7:0] OP_ADVANCE_PC     = 8'd2;
  localparam logic [7:0] OP_ADVANCE_LINE   = 8'd3;
  localparam logic [7:0] OP_SET_FILE       = 8'd4;
  localparam logic [7:0] OP_SET_COLUMN     = 8'd5;
  localparam logic [7:0] OP_NEGATE_STMT    = 8'd6;
  localparam logic [7:0] OP_SET_BLOCK      = 8'd7;
  localparam logic [7:0] OP_CONST_ADD_PC   = 8'd8;
  localparam logic [7:0] OP_FIXED_ADV_PC   = 8'd9;
  localparam logic [7:0] OP_PROLOGUE_END   = 8'd10;
  localparam logic [7:0] OP_EPILOGUE_BEGIN = 8'd11;
  localparam logic [7:0] OP_SET_ISA        = 8'd12;

  localparam logic [7:0] EXT_SEQ_END     = 8'h01;
  localparam logic [7:0] EXT_SET_ADDRESS = 8'h02;

  localparam logic KIND_ROW   = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_TRUNCATED = 2'd1;
  localparam logic [1:0] ERR_ZERO_LEN  = 2'd2;
  localparam logic [1:0] ERR_ADDR_SIZE = 2'd3;

  typedef enum logic [3:0] {
    PH_OPCODE   = 4'd0,
    PH_ULEB     = 4'd1,
    PH_SLEB     = 4'd2,
    PH_FIX_LO   = 4'd3,
    PH_FIX_HI   = 4'd4,
    PH_SKIP     = 4'd5,
    PH_EXT_LEN  = 4'd6,
    PH_EXT_SUB  = 4'd7,
    PH_EXT_BODY = 4'd8
  } phase_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic div_step;
    logic mul;
    logic add;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic need_mul;
    logic div_last;
    logic out_busy;
  } ctrl_sts_t;

endpackage

@@ rtl/lnp_intf.sv @@
// Channel interfaces of the line-number program interpreter.
interface lnp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] data_byte;
  logic [7:0] table_index;
  logic       last_byte;
  modport source (output valid, operation, data_byte, table_index, last_byte, input ready);
  modport sink (input valid, operation, data_byte, table_index, last_byte, output ready);
endinterface

interface lnp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [63:0] row_address;
  logic [31:0] row_line;
  logic [31:0] row_column;
  logic [63:0] row_file;
  logic        row_is_stmt;
  logic        row_end_sequence;
  logic [1:0]  error_code;
  modport source (output valid, kind, row_address, row_line, row_column, row_file,
                  row_is_stmt, row_end_sequence, error_code, input ready);
  modport sink (input valid, kind, row_address, row_line, row_column, row_file,
                row_is_stmt, row_end_sequence, error_code, output ready);
endinterface

interface lnp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lnp_pkg::CFG_IDX_W-1:0]  index;
  logic [7:0]                     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/lnp_ctrl.sv @@
// Sequencing state machine of the line-number program interpreter.
module lnp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lnp_pkg::ctrl_sts_t sts,
  output lnp_pkg::ctrl_cmd_t cmd
);
  import lnp_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EXEC = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_ADD  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    in_ready = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!sts.out_busy) begin
          cmd.exec = 1'b1;
          if (sts.need_div) state_next = ST_DIV;
          else if (sts.need_mul) state_next = ST_MUL;
          else state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        if (!sts.out_busy) begin
          cmd.add = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/lnp_dp.sv @@
// Datapath: line registers, operand decoding, opcode table, divider and address adder.
module lnp_dp #(
  parameter int unsigned OPCODE_TABLE_DEPTH = lnp_pkg::OPCODE_TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lnp_pkg::ctrl_cmd_t            cmd,
  output lnp_pkg::ctrl_sts_t            sts,
  input  logic [1:0]                    operation,
  input  logic [7:0]                    data_byte,
  input  logic [7:0]                    table_index,
  input  logic                          last_byte,
  input  logic                          cfg_write,
  input  logic [lnp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          kind,
  output logic [63:0]                   row_address,
  output logic [31:0]                   row_line,
  output logic [31:0]                   row_column,
  output logic [63:0]                   row_file,
  output logic                          row_is_stmt,
  output logic                          row_end_sequence,
  output logic [1:0]                    error_code
);
  import lnp_pkg::*;

  localparam int unsigned TIW = $clog2(OPCODE_TABLE_DEPTH);

  logic [7:0] min_len, line_min, line_span, first_special;
  logic       default_stmt;

  logic [1:0] op_q;
  logic [7:0] byte_q, tidx_q;
  logic       last_q;

  logic [63:0] addr, addr_n, file, file_n, acc, acc_n, ext_rem, ext_rem_n;
  logic [31:0] line, line_n, col, col_n;
  logic        stmt, stmt_n, err_lat, err_n;
  phase_t      phase, phase_n;
  logic [7:0]  cur_op, cur_n, ops_left, left_n;
  logic [6:0]  shift, shift_n;

  logic [7:0] op_table [OPCODE_TABLE_DEPTH];
  logic [OPCODE_TABLE_DEPTH-1:0] tvalid;
  logic [7:0] tdata;
  logic       tdata_valid;
  logic [7:0] op_count;
  logic       table_wr;

  logic       res_n, res_err, res_end, row_rst, need_div, need_mul, spec_n;
  logic [1:0] res_code;
  logic [7:0] div_a;

  logic        spec, src_div;
  logic [7:0]  dq, dd;
  logic [8:0]  drem, drem_sh;
  logic [2:0]  dcnt;
  logic [71:0] prod;
  logic [63:0] addr_add;
  logic [31:0] line_add;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_len <= DEF_MIN_LEN;
      line_min <= DEF_LINE_MIN;
      line_span <= DEF_LINE_SPAN;
      first_special <= DEF_FIRST_SPECIAL;
      default_stmt <= DEF_STMT;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MIN_LEN: min_len <= cfg_data;
        CFG_LINE_MIN: line_min <= cfg_data;
        CFG_LINE_SPAN: line_span <= cfg_data;
        CFG_FIRST_SPECIAL: first_special <= cfg_data;
        CFG_DEFAULT_STMT: default_stmt <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q <= operation;
      byte_q <= data_byte;
      tidx_q <= table_index;
      last_q <= last_byte;
    end
  end

  assign table_wr = cmd.exec && (op_q == OPN_LOAD) &&
                    ({1'b0, tidx_q} < 9'(OPCODE_TABLE_DEPTH));

  always_ff @(posedge clk) begin
    if (table_wr) op_table[tidx_q[TIW-1:0]] <= byte_q;
    if (cmd.load) begin
      tdata <= op_table[data_byte[TIW-1:0]];
      tdata_valid <= ({1'b0, data_byte} < 9'(OPCODE_TABLE_DEPTH)) &&
                     tvalid[data_byte[TIW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tvalid <= '0;
    end else if (table_wr) begin
      tvalid[tidx_q[TIW-1:0]] <= 1'b1;
    end
  end

  assign op_count = tdata_valid ? tdata : 8'd0;

  always_comb begin
    logic [63:0] lacc;
    logic [6:0]  lshift;
    logic        ldone;
    logic        do_finish;
    logic [64:0] fsum;
    addr_n = addr; line_n = line; col_n = col; file_n = file; stmt_n = stmt;
    phase_n = phase; cur_n = cur_op; acc_n = acc; shift_n = shift;
    ext_rem_n = ext_rem; left_n = ops_left; err_n = err_lat;
    res_n = 1'b0; res_err = 1'b0; res_code = ERR_NONE; res_end = 1'b0; row_rst = 1'b0;
    need_div = 1'b0; need_mul = 1'b0; spec_n = 1'b0; div_a = 8'd0; do_finish = 1'b0;
    fsum = '0;

    lacc = acc;
    if (shift < 7'd64) lacc = acc | ({57'd0, byte_q[6:0]} << shift);
    lshift = (shift > 7'd57) ? 7'd64 : shift + 7'd7;
    ldone = !byte_q[7];

    case (op_q)
      OPN_BEGIN: begin
        row_rst = 1'b1;
        phase_n = PH_OPCODE; cur_n = 8'd0; acc_n = '0; shift_n = '0;
        ext_rem_n = '0; left_n = '0; err_n = 1'b0;
      end
      OPN_BYTE: begin
        if (!err_lat) begin
          case (phase)
            PH_OPCODE: begin
              cur_n = byte_q;
              if (byte_q == OP_EXTENDED) begin
                acc_n = '0; shift_n = '0; phase_n = PH_EXT_LEN;
              end else if (byte_q >= first_special) begin
                need_div = 1'b1; spec_n = 1'b1; div_a = byte_q - first_special;
              end else begin
                case (byte_q)
                  OP_COPY: res_n = 1'b1;
                  OP_ADVANCE_PC, OP_SET_FILE, OP_SET_COLUMN, OP_SET_ISA: begin
                    acc_n = '0; shift_n = '0; phase_n = PH_ULEB;
                  end
                  OP_ADVANCE_LINE: begin
                    acc_n = '0; shift_n = '0; phase_n = PH_SLEB;
                  end
                  OP_NEGATE_STMT: stmt_n = !stmt;
                  OP_SET_BLOCK, OP_PROLOGUE_END, OP_EPILOGUE_BEGIN: ;
                  OP_CONST_ADD_PC: begin
                    need_div = 1'b1; div_a = 8'd255 - first_special;
                  end
                  OP_FIXED_ADV_PC: begin
                    acc_n = '0; phase_n = PH_FIX_LO;
                  end
                  default: begin
                    if (op_count != 8'd0) begin
                      left_n = op_count; acc_n = '0; shift_n = '0; phase_n = PH_SKIP;
                    end
                  end
                endcase
              end
            end
            PH_ULEB: begin
              acc_n = lacc; shift_n = lshift;
              if (ldone) begin
                if (cur_op == OP_ADVANCE_PC) need_mul = 1'b1;
                else if (cur_op == OP_SET_FILE) file_n = lacc;
                else if (cur_op == OP_SET_COLUMN) col_n = lacc[31:0];
                phase_n = PH_OPCODE;
              end
            end
            PH_SLEB: begin
              acc_n = lacc; shift_n = lshift;
              if (ldone) begin
                if (byte_q[6] && lshift < 7'd64) acc_n = lacc | ({64{1'b1}} << lshift);
                line_n = line + acc_n[31:0];
                phase_n = PH_OPCODE;
              end
            end
            PH_FIX_LO: begin
              acc_n = {56'd0, byte_q}; phase_n = PH_FIX_HI;
            end
            PH_FIX_HI: begin
              acc_n = acc | {48'd0, byte_q, 8'd0};
              fsum = {1'b0, addr} + {1'b0, acc_n};
              addr_n = fsum[64] ? {64{1'b1}} : fsum[63:0];
              phase_n = PH_OPCODE;
            end
            PH_SKIP: begin
              acc_n = lacc; shift_n = lshift;
              if (ldone) begin
                left_n = ops_left - 8'd1;
                if (left_n == 8'd0) phase_n = PH_OPCODE;
                else begin
                  acc_n = '0; shift_n = '0;
                end
              end
            end
            PH_EXT_LEN: begin
              acc_n = lacc; shift_n = lshift;
              if (ldone) begin
                if (lacc == 64'd0) begin
                  res_n = 1'b1; res_err = 1'b1; res_code = ERR_ZERO_LEN;
                  err_n = 1'b1; phase_n = PH_OPCODE;
                end else begin
                  ext_rem_n = lacc - 64'd1; phase_n = PH_EXT_SUB;
                end
              end
            end
            PH_EXT_SUB: begin
              cur_n = byte_q;
              if (byte_q == EXT_SET_ADDRESS && ext_rem != 64'd4 && ext_rem != 64'd8) begin
                res_n = 1'b1; res_err = 1'b1; res_code = ERR_ADDR_SIZE;
                err_n = 1'b1; phase_n = PH_OPCODE;
              end else begin
                acc_n = '0; shift_n = '0;
                if (ext_rem == 64'd0) do_finish = 1'b1;
                else phase_n = PH_EXT_BODY;
              end
            end
            PH_EXT_BODY: begin
              if (cur_op == EXT_SET_ADDRESS && shift < 7'd64) begin
                acc_n = acc | ({56'd0, byte_q} << shift);
                shift_n = shift + 7'd8;
              end
              ext_rem_n = ext_rem - 64'd1;
              if (ext_rem_n == 64'd0) do_finish = 1'b1;
            end
            default: phase_n = PH_OPCODE;
          endcase
          if (do_finish) begin
            phase_n = PH_OPCODE;
            if (cur_n == EXT_SEQ_END) begin
              res_n = 1'b1; res_end = 1'b1; row_rst = 1'b1;
            end else if (cur_n == EXT_SET_ADDRESS) begin
              addr_n = acc_n;
            end
          end
          if (!res_n && last_q && phase_n != PH_OPCODE) begin
            res_n = 1'b1; res_err = 1'b1; res_code = ERR_TRUNCATED;
            err_n = 1'b1; phase_n = PH_OPCODE;
          end
        end
      end
      default: ;
    endcase

    if (row_rst) begin
      addr_n = '0; line_n = 32'd1; col_n = '0; file_n = 64'd1; stmt_n = default_stmt;
    end
  end

  assign drem_sh = {drem[7:0], dq[7]};

  always_comb begin
    logic [64:0] s;
    s = {1'b0, addr} + {1'b0, prod[63:0]};
    addr_add = ((|prod[71:64]) || s[64]) ? {64{1'b1}} : s[63:0];
    line_add = line + {{24{line_min[7]}}, line_min} + {24'd0, drem[7:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0; line <= 32'd1; col <= '0; file <= 64'd1; stmt <= DEF_STMT;
      phase <= PH_OPCODE; cur_op <= '0; acc <= '0; shift <= '0;
      ext_rem <= '0; ops_left <= '0; err_lat <= 1'b0;
      dcnt <= '0; spec <= 1'b0; src_div <= 1'b0;
    end else begin
      if (cmd.exec) begin
        addr <= addr_n; line <= line_n; col <= col_n; file <= file_n; stmt <= stmt_n;
        phase <= phase_n; cur_op <= cur_n; acc <= acc_n; shift <= shift_n;
        ext_rem <= ext_rem_n; ops_left <= left_n; err_lat <= err_n;
        spec <= spec_n; src_div <= need_div; dcnt <= '0;
        dq <= div_a; drem <= '0;
        dd <= (line_span == 8'd0) ? 8'd1 : line_span;
      end
      if (cmd.div_step) begin
        dcnt <= dcnt + 3'd1;
        if (drem_sh >= {1'b0, dd}) begin
          drem <= drem_sh - {1'b0, dd};
          dq <= {dq[6:0], 1'b1};
        end else begin
          drem <= drem_sh;
          dq <= {dq[6:0], 1'b0};
        end
      end
      if (cmd.mul) begin
        prod <= {64'd0, min_len} * (src_div ? {64'd0, dq} : {8'd0, acc});
      end
      if (cmd.add) begin
        addr <= addr_add;
        if (spec) line <= line_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if ((cmd.exec && res_n) || (cmd.add && spec)) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && res_n) begin
      kind <= res_err ? KIND_ERROR : KIND_ROW;
      error_code <= res_code;
      row_address <= res_err ? 64'd0 : addr;
      row_line <= res_err ? 32'd0 : line;
      row_column <= res_err ? 32'd0 : col;
      row_file <= res_err ? 64'd0 : file;
      row_is_stmt <= res_err ? 1'b0 : stmt;
      row_end_sequence <= res_end;
    end else if (cmd.add && spec) begin
      kind <= KIND_ROW;
      error_code <= ERR_NONE;
      row_address <= addr_add;
      row_line <= line_add;
      row_column <= col;
      row_file <= file;
      row_is_stmt <= stmt;
      row_end_sequence <= 1'b0;
    end
  end

  assign sts.need_div = need_div;
  assign sts.need_mul = need_mul;
  assign sts.div_last = (dcnt == 3'd7);
  assign sts.out_busy = out_valid && !out_ready;

endmodule

@@ rtl/line_number_program_interpreter_top.sv @@
// Top level of the line-number program interpreter.
// The block takes one input transfer at a time. A table load, begin-unit or plain program
// byte is accepted and then executed; the byte that ends an advance_pc operand also goes
// through a multiply and a saturating address add; a special opcode or const_add_pc first
// passes its advance through a radix-2 divider before the multiply and add. A result waiting
// in the output register stalls the next execute or address add only while it is not taken.
// The operand-count table is cleared at reset through per-entry valid bits, with no sweep.
module line_number_program_interpreter_top #(
  parameter int unsigned OPCODE_TABLE_DEPTH = lnp_pkg::OPCODE_TABLE_DEPTH_DEF
) (
  input logic        clk,
  input logic        rst,
  lnp_in_if.sink     req,
  lnp_out_if.source  rsp,
  lnp_cfg_if.sink    cfg
);
  import lnp_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  assign cfg.ready = 1'b1;

  lnp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lnp_dp #(.OPCODE_TABLE_DEPTH(OPCODE_TABLE_DEPTH)) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .operation        (req.operation),
    .data_byte        (req.data_byte),
    .table_index      (req.table_index),
    .last_byte        (req.last_byte),
    .cfg_write        (cfg.valid),
    .cfg_index        (cfg.index),
    .cfg_data         (cfg.data),
    .out_ready        (rsp.ready),
    .out_valid        (rsp.valid),
    .kind             (rsp.kind),
    .row_address      (rsp.row_address),
    .row_line         (rsp.row_line),
    .row_column       (rsp.row_column),
    .row_file         (rsp.row_file),
    .row_is_stmt      (rsp.row_is_stmt),
    .row_end_sequence (rsp.row_end_sequence),
    .error_code       (rsp.error_code)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("input accepted while an item is in flight");

  a_row_code: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.kind == KIND_ROW |-> rsp.error_code == ERR_NONE)
    else $error("row carries an error code");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.kind == KIND_ERROR |->
      rsp.error_code != ERR_NONE && rsp.row_address == 64'd0 && rsp.row_line == 32'd0 &&
      !rsp.row_end_sequence)
    else $error("malformed error report");

endmodule

@@ bench/tb_line_number_program_interpreter_top.sv @@
// Self-checking bench for the line-number program interpreter: directed and random programs.
module tb_line_number_program_interpreter_top;
  import lnp_pkg::*;

  localparam int unsigned TABLE_DEPTH = OPCODE_TABLE_DEPTH_DEF;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam logic [63:0] ONES = 64'hffff_ffff_ffff_ffff;

  typedef struct packed {
    logic        kind;
    logic [63:0] address;
    logic [31:0] line;
    logic [31:0] column;
    logic [63:0] file;
    logic        is_stmt;
    logic        end_seq;
    logic [1:0]  code;
  } line_row_t;

  logic clk;
  logic rst;
  lnp_in_if  req ();
  lnp_out_if rsp ();
  lnp_cfg_if cfg ();

  line_number_program_interpreter_top u_top (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
  );

  // Configuration copy.
  logic [7:0] min_len, line_min, line_span, first_special;
  logic       dflt_stmt;
  // Line state copy.
  logic [63:0] address_q, file_q, accum_q, ext_left_q;
  logic [31:0] line_q, column_q;
  logic        stmt_q, err_q;
  phase_t      phase_q;
  logic [7:0]  opcode_q, skip_left_q;
  int unsigned shift_q;
  logic [7:0]  count_table [TABLE_DEPTH];

  line_row_t expected_rows[$];
  int unsigned errors;
  int unsigned idle_cycles;
  int unsigned send_idle_pct, recv_idle_pct;
  bit          hold_off;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic void regs_reset();
    address_q = '0;
    line_q = 32'd1;
    column_q = '0;
    file_q = 64'd1;
    stmt_q = dflt_stmt;
  endfunction

  function automatic void unit_reset();
    regs_reset();
    phase_q = PH_OPCODE;
    opcode_q = '0;
    accum_q = '0;
    shift_q = 0;
    ext_left_q = '0;
    skip_left_q = '0;
    err_q = 1'b0;
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] d);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, d};
    return s[64] ? ONES : s[63:0];
  endfunction

  function automatic void advance_ops(input logic [63:0] ops);
    logic [71:0] prod;
    prod = ops * {64'd0, min_len};
    if (prod[71:64] != 0) address_q = ONES;
    else address_q = sat_add(address_q, prod[63:0]);
  endfunction

  function automatic logic leb_take(input logic [7:0] b, input logic signed_leb);
    if (shift_q < 64) accum_q |= {57'd0, b[6:0]} << shift_q;
    shift_q = (shift_q + 7 > 64) ? 64 : shift_q + 7;
    if (b[7]) return 1'b0;
    if (signed_leb && b[6] && shift_q < 64) accum_q |= ONES << shift_q;
    return 1'b1;
  endfunction

  function automatic line_row_t make_row(input logic end_seq);
    line_row_t r;
    r = '{KIND_ROW, address_q, line_q, column_q, file_q, stmt_q, end_seq, ERR_NONE};
    return r;
  endfunction

  function automatic line_row_t make_error(input logic [1:0] code);
    line_row_t r;
    r = '0;
    r.kind = KIND_ERROR;
    r.code = code;
    err_q = 1'b1;
    phase_q = PH_OPCODE;
    return r;
  endfunction

  function automatic bit finish_ext(output line_row_t r);
    phase_q = PH_OPCODE;
    if (opcode_q == EXT_SEQ_END) begin
      r = make_row(1'b1);
      regs_reset();
      return 1;
    end
    if (opcode_q == EXT_SET_ADDRESS) address_q = accum_q;
    return 0;
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, output line_row_t r);
    int unsigned rng, adj;
    int signed ladv;
    logic [7:0] cnt;
    case (phase_q)
      PH_OPCODE: begin
        opcode_q = b;
        rng = (line_span == 0) ? 1 : line_span;
        if (b == OP_EXTENDED) begin
          accum_q = '0; shift_q = 0; phase_q = PH_EXT_LEN;
        end else if (b >= first_special) begin
          adj = b - first_special;
          ladv = $signed(line_min) + int'(adj % rng);
          advance_ops(64'(adj / rng));
          line_q = line_q + 32'(ladv);
          r = make_row(1'b0);
          return 1;
        end else begin
          case (b)
            OP_COPY: begin
              r = make_row(1'b0);
              return 1;
            end
            OP_ADVANCE_PC, OP_SET_FILE, OP_SET_COLUMN, OP_SET_ISA: begin
              accum_q = '0; shift_q = 0; phase_q = PH_ULEB;
            end
            OP_ADVANCE_LINE: begin
              accum_q = '0; shift_q = 0; phase_q = PH_SLEB;
            end
            OP_NEGATE_STMT: stmt_q = ~stmt_q;
            OP_SET_BLOCK, OP_PROLOGUE_END, OP_EPILOGUE_BEGIN: ;
            OP_CONST_ADD_PC: advance_ops(64'((255 - first_special) / rng));
            OP_FIXED_ADV_PC: begin
              accum_q = '0; phase_q = PH_FIX_LO;
            end
            default: begin
              cnt = (b < TABLE_DEPTH) ? count_table[b] : 8'd0;
              if (cnt != 0) begin
                skip_left_q = cnt;
                accum_q = '0; shift_q = 0; phase_q = PH_SKIP;
              end
            end
          endcase
        end
      end
      PH_ULEB: begin
        if (leb_take(b, 1'b0)) begin
          if (opcode_q == OP_ADVANCE_PC) advance_ops(accum_q);
          else if (opcode_q == OP_SET_FILE) file_q = accum_q;
          else if (opcode_q == OP_SET_COLUMN) column_q = accum_q[31:0];
          phase_q = PH_OPCODE;
        end
      end
      PH_SLEB: begin
        if (leb_take(b, 1'b1)) begin
          line_q = line_q + accum_q[31:0];
          phase_q = PH_OPCODE;
        end
      end
      PH_FIX_LO: begin
        accum_q = {56'd0, b}; phase_q = PH_FIX_HI;
      end
      PH_FIX_HI: begin
        accum_q |= {48'd0, b, 8'd0};
        address_q = sat_add(address_q, accum_q);
        phase_q = PH_OPCODE;
      end
      PH_SKIP: begin
        if (leb_take(b, 1'b0)) begin
          skip_left_q--;
          if (skip_left_q == 0) phase_q = PH_OPCODE;
          else begin
            accum_q = '0; shift_q = 0;
          end
        end
      end
      PH_EXT_LEN: begin
        if (leb_take(b, 1'b0)) begin
          if (accum_q == 0) begin
            r = make_error(ERR_ZERO_LEN);
            return 1;
          end
          ext_left_q = accum_q - 1;
          phase_q = PH_EXT_SUB;
        end
      end
      PH_EXT_SUB: begin
        opcode_q = b;
        if (b == EXT_SET_ADDRESS && ext_left_q != 4 && ext_left_q != 8) begin
          r = make_error(ERR_ADDR_SIZE);
          return 1;
        end
        accum_q = '0; shift_q = 0;
        if (ext_left_q == 0) return finish_ext(r);
        phase_q = PH_EXT_BODY;
      end
      PH_EXT_BODY: begin
        if (opcode_q == EXT_SET_ADDRESS && shift_q < 64) begin
          accum_q |= {56'd0, b} << shift_q;
          shift_q += 8;
        end
        ext_left_q--;
        if (ext_left_q == 0) return finish_ext(r);
      end
      default: phase_q = PH_OPCODE;
    endcase
    return 0;
  endfunction

  function automatic void predict(input logic [1:0] op, input logic [7:0] b,
                                  input logic [7:0] idx, input logic last);
    line_row_t r;
    bit got;
    if (op == OPN_LOAD) begin
      if (idx < TABLE_DEPTH) count_table[idx] = b;
      return;
    end
    if (op == OPN_BEGIN) begin
      unit_reset();
      return;
    end
    if (op != OPN_BYTE || err_q) return;
    got = decode_byte(b, r);
    if (!got && last && phase_q != PH_OPCODE) begin
      r = make_error(ERR_TRUNCATED);
      got = 1;
    end
    if (got) expected_rows.push_back(r);
  endfunction

  task automatic send(input logic [1:0] op, input logic [7:0] b,
                      input logic [7:0] idx = 8'd0, input logic last = 1'b0);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    req.valid <= 1'b1;
    req.operation <= op;
    req.data_byte <= b;
    req.table_index <= idx;
    req.last_byte <= last;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    predict(op, b, idx, last);
    req.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    case (idx)
      CFG_MIN_LEN: min_len = val;
      CFG_LINE_MIN: line_min = val;
      CFG_LINE_SPAN: line_span = val;
      CFG_FIRST_SPECIAL: first_special = val;
      CFG_DEFAULT_STMT: dflt_stmt = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] ml, input logic [7:0] lb, input logic [7:0] lr,
                           input logic [7:0] ob, input logic ds);
    drain();
    write_reg(CFG_MIN_LEN, ml);
    write_reg(CFG_LINE_MIN, lb);
    write_reg(CFG_LINE_SPAN, lr);
    write_reg(CFG_FIRST_SPECIAL, ob);
    write_reg(CFG_DEFAULT_STMT, ds);
    send(OPN_BEGIN, 8'd0);
  endtask

  task automatic send_leb(input logic [63:0] v, input int unsigned extra = 0);
    do begin
      send(OPN_BYTE, {(v >> 7) != 0 || extra != 0, v[6:0]});
      v = v >> 7;
    end while (v != 0);
    while (extra != 0) begin
      extra--;
      send(OPN_BYTE, {extra != 0, 7'($urandom)});
    end
  endtask

  task automatic test_directed();
    send(OPN_BYTE, OP_COPY);
    send(OPN_BYTE, 8'd255);
    send(OPN_BYTE, OP_ADVANCE_PC); send_leb(ONES, 2);
    send(OPN_BYTE, OP_CONST_ADD_PC);
    send(OPN_BYTE, OP_ADVANCE_LINE); send_leb(64'h7f);
    send(OPN_BYTE, OP_SET_FILE); send_leb(64'h8000_0000_0000_0001);
    send(OPN_BYTE, OP_SET_COLUMN); send_leb(64'h1_2345_6789);
    send(OPN_BYTE, OP_NEGATE_STMT);
    send(OPN_BYTE, OP_FIXED_ADV_PC); send(OPN_BYTE, 8'hff); send(OPN_BYTE, 8'hff);
    send(OPN_BYTE, OP_COPY);
    send(OPN_LOAD, 8'd2, 8'd12); send(OPN_LOAD, 8'd1, 8'd255);
    send(OPN_BYTE, OP_EXTENDED); send(OPN_BYTE, 8'd9); send(OPN_BYTE, EXT_SET_ADDRESS);
    repeat (8) send(OPN_BYTE, 8'hff);
    send(OPN_BYTE, OP_EXTENDED); send(OPN_BYTE, 8'd1);
    send(OPN_BYTE, EXT_SEQ_END, 8'd0, 1'b1);
    send(OPN_BYTE, OP_EXTENDED); send(OPN_BYTE, 8'd0);
    send(OPN_BYTE, OP_COPY);
    send(OPN_BEGIN, 8'd0);
    send(OPN_BYTE, OP_EXTENDED); send(OPN_BYTE, 8'd3); send(OPN_BYTE, EXT_SET_ADDRESS);
    send(OPN_BEGIN, 8'd0);
    send(OPN_BYTE, OP_ADVANCE_PC, 8'd0, 1'b1);
    send(OPN_BEGIN, 8'd0);
    send(OPN_LOAD, 8'd0, 8'd255);
  endtask

  task automatic random_instr(input logic last_mark);
    logic [7:0] op;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8) begin
      send(OPN_BYTE, 8'($urandom), 8'($urandom), last_mark);
      return;
    end
    if (pick < 30) op = 8'($urandom_range(255, first_special));
    else op = 8'($urandom_range(16, 1));
    if (pick >= 90) begin
      send(OPN_BYTE, OP_EXTENDED);
      if ($urandom_range(9) == 0) begin
        send(OPN_BYTE, 8'd0, 8'd0, last_mark);
        return;
      end
      pick = $urandom_range(3);
      if (pick == 0) begin
        send(OPN_BYTE, 8'd1); send(OPN_BYTE, EXT_SEQ_END, 8'd0, last_mark);
      end else if (pick == 1) begin
        pick = $urandom_range(1) ? 9 : ($urandom_range(1) ? 5 : $urandom_range(8, 1));
        send(OPN_BYTE, 8'(pick)); send(OPN_BYTE, EXT_SET_ADDRESS);
        repeat (pick - 1) send(OPN_BYTE, 8'($urandom), 8'd0, last_mark);
      end else begin
        pick = $urandom_range(4, 1);
        send(OPN_BYTE, 8'(pick)); send(OPN_BYTE, 8'($urandom_range(255, 3)));
        repeat (pick - 1) send(OPN_BYTE, 8'($urandom));
      end
      return;
    end
    send(OPN_BYTE, op, 8'd0, last_mark && op >= first_special);
    if (op >= first_special) return;
    case (op)
      OP_ADVANCE_PC, OP_SET_FILE, OP_SET_COLUMN, OP_SET_ISA, OP_ADVANCE_LINE:
        send_leb($urandom_range(1) ? 64'($urandom_range(300)) : {$urandom, $urandom},
                 $urandom_range(9) == 0 ? 3 : 0);
      OP_FIXED_ADV_PC: begin
        send(OPN_BYTE, 8'($urandom)); send(OPN_BYTE, 8'($urandom));
      end
      default:
        if (op > OP_SET_ISA && count_table[op] != 0)
          repeat (count_table[op]) send_leb($urandom_range(200));
    endcase
  endtask

  task automatic test_random(input int unsigned n);
    int unsigned k;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(40) == 0) send(OPN_BEGIN, 8'd0);
      else if ($urandom_range(60) == 0)
        send(OPN_LOAD, 8'($urandom_range(3)), 8'($urandom_range(20, 10)));
      else if ($urandom_range(200) == 0) send(OPN_NONE, 8'($urandom));
      else random_instr($urandom_range(30) == 0);
    end
  endtask

  task automatic test_back_pressure();
    int unsigned k;
    hold_off = 1'b1;
    for (k = 0; k < 8; k++) send(OPN_BYTE, OP_COPY);
    hold_off = 1'b0;
    drain();
    send(OPN_BYTE, OP_COPY);
  endtask

  initial begin
    errors = 0;
    hold_off = 1'b0;
    send_idle_pct = 28;
    recv_idle_pct = 83;
    rst = 1'b1;
    req.valid = 1'b0; req.operation = '0; req.data_byte = '0;
    req.table_index = '0; req.last_byte = 1'b0;
    cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
    min_len = DEF_MIN_LEN; line_min = DEF_LINE_MIN; line_span = DEF_LINE_SPAN;
    first_special = DEF_FIRST_SPECIAL; dflt_stmt = DEF_STMT;
    foreach (count_table[i]) count_table[i] = '0;
    unit_reset();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_back_pressure();
    test_random(100);
    configure(8'd255, 8'h80, 8'd0, 8'd0, 1'b0);
    test_directed();
    test_random(60);
    configure(8'd0, 8'h7f, 8'd255, 8'd255, 1'b1);
    test_random(60);
    send_idle_pct = 83;
    recv_idle_pct = 28;
    configure(8'd4, 8'hfd, 8'd12, 8'd10, 1'b0);
    test_random(100);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(DEF_MIN_LEN, DEF_LINE_MIN, DEF_LINE_SPAN, DEF_FIRST_SPECIAL, DEF_STMT);
    test_random(140);
    drain();
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // Receiver: random or held-off ready.
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        rsp.ready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    line_row_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_rows.size() == 0) report("unexpected result");
      else begin
        want = expected_rows.pop_front();
        if (rsp.kind !== want.kind) report($sformatf("kind %0d/%0d", rsp.kind, want.kind));
        if (rsp.row_address !== want.address)
          report($sformatf("address %h/%h", rsp.row_address, want.address));
        if (rsp.row_line !== want.line) report($sformatf("line %h/%h", rsp.row_line, want.line));
        if (rsp.row_column !== want.column)
          report($sformatf("column %h/%h", rsp.row_column, want.column));
        if (rsp.row_file !== want.file) report($sformatf("file %h/%h", rsp.row_file, want.file));
        if (rsp.row_is_stmt !== want.is_stmt) report("is_stmt");
        if (rsp.row_end_sequence !== want.end_seq) report("sequence end flag");
        if (rsp.error_code !== want.code) report($sformatf("error code %0d/%0d",
                                                          rsp.error_code, want.code));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

endmodule
